// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while out of reset.
`define AST_CHK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("check failed");

// Property checked on every clock edge, reset included.
`define AST_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("check failed");

`endif

// ===== rtl/trle_pkg.sv =====
// Shared types and constants of the TGA run-length decoder.
`timescale 1ns / 1ps
package trle_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int RUN_CHUNK    = 2;       // pixels per result of a run
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic [7:0] RUN_MARK   = 8'h80;
  localparam logic [7:0] COUNT_MASK = 8'h7F;

  // Configuration register indexes
  localparam logic CFG_CHANNELS     = 1'b0;
  localparam logic CFG_IMAGE_PIXELS = 1'b1;

  // One command from the front to the back: a pixel given count times
  typedef struct packed {
    logic [31:0] pixel;
    logic [7:0]  count;    // 1..128 pixels to give
    logic        done;     // last result completes the image
    logic        err;      // header overflow, no pixel data
  } cmd_t;

endpackage

// ===== rtl/tga_rle_decoder_top.sv =====
// Top level of the TGA run-length decoder: config registers and block wiring.
//
// Input channel (in_valid/in_ready/in_data_byte): one byte of the coded
// pixel stream per transfer. A header byte opens a run packet (bit 7 set) or
// a raw packet; its low 7 bits plus one give the pixel count.
// Output channel (out_valid/out_ready/out_*): one result per transfer, up to
// two copies of a run pixel, one raw pixel, or an overflow error.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 sets
// channels, index 1 sets image_pixels. Always ready; write only while idle.
// A completing byte's command passes the command queue, the expander's
// work register and the output register. One byte per cycle while in_ready
// is high; runs leave two pixels per result (an odd last one alone), raw
// pixels one per cycle while queued and out_ready high. A 4-entry queue parts
// the byte parser from the run expander; in_ready drops only when it is full.
// Reset: synchronous, clears control state; channels = 4, image_pixels = 1.
// When the receiver stalls, the result holds in the output register, the
// expander and then the queue fill, and the input is back-pressured.
`timescale 1ns / 1ps
module tga_rle_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel_first,
  output logic [31:0] out_pixel_second,
  output logic [1:0]  out_pixels_valid,
  output logic        out_last_of_burst,
  output logic        out_image_done,
  output logic        out_overflow_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [2:0]     channels_r;
  logic [31:0]    image_pixels_r;
  logic           push;
  trle_pkg::cmd_t push_cmd;
  trle_pkg::cmd_t head;
  logic           pop;
  logic           fifo_empty;
  logic           fifo_full;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_r     <= 3'd4;
      image_pixels_r <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        trle_pkg::CFG_CHANNELS:     channels_r     <= cfg_data[2:0];
        trle_pkg::CFG_IMAGE_PIXELS: image_pixels_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  trle_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_ready     (in_ready),
    .channels     (channels_r),
    .image_pixels (image_pixels_r),
    .fifo_full    (fifo_full),
    .push         (push),
    .cmd          (push_cmd)
  );

  trle_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (push_cmd),
    .rd_en   (pop),
    .rd_data (head),
    .empty   (fifo_empty),
    .full    (fifo_full)
  );

  trle_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .fifo_empty         (fifo_empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pixel_first    (out_pixel_first),
    .out_pixel_second   (out_pixel_second),
    .out_pixels_valid   (out_pixels_valid),
    .out_last_of_burst  (out_last_of_burst),
    .out_image_done     (out_image_done),
    .out_overflow_error (out_overflow_error)
  );

endmodule

// ===== rtl/trle_front.sv =====
// Front end: takes stream bytes, parses packets, assembles pixels, counts pixels.
`timescale 1ns / 1ps
module trle_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_data_byte,
  output logic               in_ready,
  input  logic [2:0]         channels,
  input  logic [31:0]        image_pixels,
  input  logic               fifo_full,
  output logic               push,
  output trle_pkg::cmd_t     cmd
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_RUN    = 2'd1;
  localparam logic [1:0] PH_RAW    = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [31:0] asm_r, asm_nxt;
  logic [31:0] pd_r, pd_nxt;

  logic        fire;
  logic [2:0]  ch_eff;
  logic [32:0] diff;
  logic        diff_nonpos;
  logic [7:0]  hdr_count;
  logic        hdr_err;
  logic [31:0] px_full;
  logic        px_complete;
  logic        run_done;
  logic [8:0]  run_round;
  logic [8:0]  run_lim;
  logic [7:0]  run_emit;
  logic        raw_done;
  logic [7:0]  raw_left_dec;

  assign in_ready = !fifo_full;
  assign fire     = in_valid && in_ready;

  // Effective bytes per pixel, clamped to 1..MAX_CHANNELS
  always_comb begin
    ch_eff = channels;
    if (channels == 3'd0) begin
      ch_eff = 3'd1;
    end else if (channels > 3'(trle_pkg::MAX_CHANNELS)) begin
      ch_eff = 3'(trle_pkg::MAX_CHANNELS);
    end
  end

  // Pixels still to go before the image is full (negative after a shrink)
  assign diff        = {1'b0, image_pixels} - {1'b0, pd_r};
  assign diff_nonpos = diff[32] || (diff == 33'd0);

  // Header: count and overflow check (count > remaining)
  assign hdr_count = {1'b0, in_data_byte[6:0] & trle_pkg::COUNT_MASK[6:0]} + 8'd1;
  assign hdr_err   = diff[32] || ((diff[31:8] == 24'd0) && (diff[7:0] < hdr_count));

  // Pixel assembly
  assign px_full     = asm_r | ({24'd0, in_data_byte} << {bip_r, 3'b000});
  assign px_complete = ({1'b0, bip_r} + 3'd1) >= ch_eff;

  // Run: image completes within this run when remaining <= count
  assign run_done  = diff[32] || ((diff[31:8] == 24'd0) && (diff[7:0] <= left_r));
  assign run_round = {1'b0, diff[7:0]} + {8'd0, diff[0]};
  assign run_lim   = diff_nonpos ? 9'(trle_pkg::RUN_CHUNK) : run_round;
  // Whole packet unless the image fills first, then up to the covering pair
  assign run_emit  = (!run_done || ({1'b0, left_r} <= run_lim)) ? left_r : run_lim[7:0];

  // Raw: one pixel completes the image when remaining <= 1
  assign raw_done     = diff[32] || (diff[31:1] == 31'd0);
  assign raw_left_dec = (left_r != 8'd0) ? (left_r - 8'd1) : 8'd0;

  // Next state and command
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    bip_nxt   = bip_r;
    asm_nxt   = asm_r;
    pd_nxt    = pd_r;
    push      = 1'b0;
    cmd.pixel = 32'd0;
    cmd.count = 8'd1;
    cmd.done  = 1'b0;
    cmd.err   = 1'b0;
    if (fire) begin
      case (phase_r)
        PH_HEADER: begin
          if (hdr_err) begin
            push    = 1'b1;
            cmd.err = 1'b1;
          end else begin
            left_nxt  = hdr_count;
            phase_nxt = ((in_data_byte & trle_pkg::RUN_MARK) != 8'd0) ? PH_RUN : PH_RAW;
            bip_nxt   = 2'd0;
            asm_nxt   = 32'd0;
          end
        end
        PH_RUN, PH_RAW: begin
          if (!px_complete) begin
            asm_nxt = px_full;
            bip_nxt = bip_r + 2'd1;
          end else begin
            bip_nxt   = 2'd0;
            asm_nxt   = 32'd0;
            push      = 1'b1;
            cmd.pixel = px_full;
            if (phase_r == PH_RUN) begin
              phase_nxt = PH_HEADER;
              left_nxt  = 8'd0;
              cmd.count = run_emit;
              cmd.done  = run_done;
              pd_nxt    = run_done ? 32'd0 : (pd_r + {24'd0, left_r});
            end else begin
              cmd.count = 8'd1;
              cmd.done  = raw_done;
              pd_nxt    = raw_done ? 32'd0 : (pd_r + 32'd1);
              left_nxt  = raw_done ? 8'd0 : raw_left_dec;
              if (raw_done || (raw_left_dec == 8'd0)) begin
                phase_nxt = PH_HEADER;
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      left_r  <= 8'd0;
      bip_r   <= 2'd0;
      asm_r   <= 32'd0;
      pd_r    <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      bip_r   <= bip_nxt;
      asm_r   <= asm_nxt;
      pd_r    <= pd_nxt;
    end
  end

endmodule

// ===== rtl/trle_fifo.sv =====
// Short command queue between the front end and the run expander.
`timescale 1ns / 1ps
module trle_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  trle_pkg::cmd_t     wr_data,
  input  logic               rd_en,
  output trle_pkg::cmd_t     rd_data,
  output logic               empty,
  output logic               full
);

  trle_pkg::cmd_t                  mem_r [trle_pkg::FIFO_DEPTH];
  logic [trle_pkg::FIFO_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [trle_pkg::FIFO_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [trle_pkg::FIFO_AW:0]      cnt_r, cnt_nxt;
  logic                            do_wr;
  logic                            do_rd;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (trle_pkg::FIFO_AW+1)'(trle_pkg::FIFO_DEPTH));
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_wr ? (wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? (rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/trle_back.sv =====
// Back end: expands commands into results, up to two pixels per result for runs.
`timescale 1ns / 1ps
module trle_back (
  input  logic               clk,
  input  logic               rst_n,
  input  trle_pkg::cmd_t     head,
  input  logic               fifo_empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_pixel_first,
  output logic [31:0]        out_pixel_second,
  output logic [1:0]         out_pixels_valid,
  output logic               out_last_of_burst,
  output logic               out_image_done,
  output logic               out_overflow_error
);

  // Work register: command being expanded
  logic        w_valid_r, w_valid_nxt;
  logic [31:0] w_px_r, w_px_nxt;
  logic [7:0]  w_left_r, w_left_nxt;
  logic        w_done_r, w_done_nxt;
  logic        w_err_r, w_err_nxt;

  // Output register
  logic        o_valid_r, o_valid_nxt;
  logic [31:0] o_p1_r, o_p2_r;
  logic [1:0]  o_pv_r;
  logic        o_last_r, o_done_r, o_err_r;

  logic        emit;
  logic [1:0]  n;
  logic [7:0]  left_after;
  logic        last;
  logic        take;

  assign emit       = w_valid_r && (!o_valid_r || out_ready);
  assign n          = (w_left_r >= 8'(trle_pkg::RUN_CHUNK)) ? 2'(trle_pkg::RUN_CHUNK)
                                                           : w_left_r[1:0];
  assign left_after = w_left_r - {6'd0, n};
  assign last       = (left_after == 8'd0);
  assign take       = !w_valid_r || (emit && last);
  assign pop        = take && !fifo_empty;

  // Work register update: reload when empty or on the last chunk, else count down
  always_comb begin
    w_valid_nxt = w_valid_r;
    w_px_nxt    = w_px_r;
    w_left_nxt  = w_left_r;
    w_done_nxt  = w_done_r;
    w_err_nxt   = w_err_r;
    if (take) begin
      w_valid_nxt = !fifo_empty;
      w_px_nxt    = head.pixel;
      w_left_nxt  = head.count;
      w_done_nxt  = head.done;
      w_err_nxt   = head.err;
    end else if (emit) begin
      w_left_nxt = left_after;
    end
  end

  // Output valid: set on emit, cleared on transfer
  always_comb begin
    o_valid_nxt = o_valid_r;
    if (emit) begin
      o_valid_nxt = 1'b1;
    end else if (out_ready) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      w_valid_r <= w_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    w_px_r   <= w_px_nxt;
    w_left_r <= w_left_nxt;
    w_done_r <= w_done_nxt;
    w_err_r  <= w_err_nxt;
    if (emit) begin
      o_p1_r   <= w_err_r ? 32'd0 : w_px_r;
      o_p2_r   <= (!w_err_r && (n == 2'd2)) ? w_px_r : 32'd0;
      o_pv_r   <= w_err_r ? 2'd0 : n;
      o_last_r <= last;
      o_done_r <= w_done_r && last;
      o_err_r  <= w_err_r;
    end
  end

  assign out_valid          = o_valid_r;
  assign out_pixel_first    = o_p1_r;
  assign out_pixel_second   = o_p2_r;
  assign out_pixels_valid   = o_pv_r;
  assign out_last_of_burst  = o_last_r;
  assign out_image_done     = o_done_r;
  assign out_overflow_error = o_err_r;

endmodule

// ===== rtl/trle_chk.sv =====
// Port-level checker for the TGA run-length decoder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trle_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel_first,
  input logic [31:0] out_pixel_second,
  input logic [1:0]  out_pixels_valid,
  input logic        out_last_of_burst,
  input logic        out_image_done,
  input logic        out_overflow_error
);

  // Nothing is offered in the cycle after reset
  `AST_ALL(a_idle_after_reset, clk, $past(!rst_n) |-> !out_valid)

  // A stalled result stays offered
  `AST_CHK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)

  // Error results carry no pixels and close the burst
  `AST_CHK(a_err_shape, clk, rst_n, out_valid && out_overflow_error |-> out_pixels_valid == 2'd0 && out_last_of_burst && !out_image_done)

  // Image completion ends a burst and carries pixels
  `AST_CHK(a_done_last, clk, rst_n, out_valid && out_image_done |-> out_last_of_burst && out_pixels_valid != 2'd0)

  // A pixel pair is always two copies of the same run pixel
  `AST_CHK(a_pair_same, clk, rst_n, out_valid && out_pixels_valid == 2'd2 |-> out_pixel_first == out_pixel_second)

endmodule

bind tga_rle_decoder_top trle_chk u_trle_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_pixel_first    (out_pixel_first),
  .out_pixel_second   (out_pixel_second),
  .out_pixels_valid   (out_pixels_valid),
  .out_last_of_burst  (out_last_of_burst),
  .out_image_done     (out_image_done),
  .out_overflow_error (out_overflow_error)
);
